>>> src/fcrb_pkg.sv
// Shared types for the frame capture register bridge.
// Command codes, result kinds and the stage record passed to the output stage.
// No dependencies.
`default_nettype none

package fcrb_pkg;

    typedef enum logic [2:0] {
        CMD_STREAM     = 3'd0,
        CMD_ADDR       = 3'd1,
        CMD_TEMP       = 3'd2,
        CMD_DUMP_START = 3'd3,
        CMD_DUMP_NEXT  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_READ_NEW,
        RES_READ_OLD,
        RES_DUMP
    } res_kind_t;

    typedef logic [1:0] reg_index_t;

    localparam reg_index_t REG_HEADER_FIRST  = 2'd0;
    localparam reg_index_t REG_HEADER_SECOND = 2'd1;

    // One accepted word on its way to the output register
    typedef struct packed {
        res_kind_t  kind;
        logic       status;
        logic       use_ram;
        logic [7:0] fixed_val;
    } stage_t;

endpackage

`default_nettype wire

>>> src/fcrb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fcrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic                             re,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> src/fcrb_temp.sv
// Fixed-point temperature from a 12-bit converter sample:
// floor(5386 - sample * 196465 / 65536), saturated at zero.
// No dependencies.
`default_nettype none

module fcrb_temp (
    input  wire logic [11:0] sample,
    output logic      [12:0] temp
);

    localparam logic [29:0] OFFSET_Q16 = 30'd352976896;  // 5386 << 16
    localparam logic [17:0] SLOPE_Q16  = 18'd196465;

    logic [29:0] prod;
    logic [29:0] diff;

    always_comb
    begin
        prod = 30'(sample * SLOPE_Q16);
        diff = OFFSET_Q16 - prod;
        if (prod >= OFFSET_Q16)
        begin
            temp = '0;
        end
        else
        begin
            temp = diff[28:16];
        end
    end

endmodule

`default_nettype wire

>>> src/fcrb_out.sv
// Output stage: merges RAM read data with the stage record, keeps the
// pending address-link byte and drives the result register.
// Depends on fcrb_pkg.
`default_nettype none

module fcrb_out (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s1_valid,
    input  wire fcrb_pkg::stage_t s1,
    input  wire logic [7:0]       ram_q,
    output logic                  out_free,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic      [15:0]      m_tdata,   // read_byte[7:0], dump_byte[15:8]
    output logic      [1:0]       m_tuser    // status[0], dump_valid[1]
);

    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [15:0] m_tdata_reg;
    logic [15:0] m_tdata_next;
    logic [1:0]  m_tuser_reg;
    logic [1:0]  m_tuser_next;
    logic [7:0]  pending_reg;
    logic [7:0]  pending_next;
    logic [7:0]  value;
    logic        load;

    assign out_free = !m_tvalid_reg || m_tready;
    assign load     = s1_valid && out_free;
    assign value    = s1.use_ram ? ram_q : s1.fixed_val;

    always_comb
    begin
        pending_next  = pending_reg;
        m_tdata_next  = '0;
        m_tuser_next  = {1'b0, s1.status};
        unique case (s1.kind)
            fcrb_pkg::RES_NONE:
            begin
            end
            fcrb_pkg::RES_READ_NEW:
            begin
                pending_next      = value;
                m_tdata_next[7:0] = value;
            end
            fcrb_pkg::RES_READ_OLD:
            begin
                m_tdata_next[7:0] = pending_reg;
            end
            fcrb_pkg::RES_DUMP:
            begin
                m_tdata_next[15:8] = value;
                m_tuser_next[1]    = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            pending_reg  <= '0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
            if (load)
            begin
                pending_reg <= pending_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

>>> src/frame_capture_register_bridge.sv
// Frame capture register bridge: byte stream into a frame buffer, address
// reads and dump readout. Depends on fcrb_pkg, fcrb_ram, fcrb_temp, fcrb_out.
//
// Usage:
//   s_* carries one command word per handshake: tuser holds the command,
//   tdata holds the stream byte or read address, the address-received flag
//   and the converter sample. m_* returns exactly one result word per command.
//   cfg_we/cfg_index/cfg_wdata write the two header bytes; write them only
//   while no command is in flight.
// Timing:
//   A word's result reaches m_* through the buffer RAM's registered read, held
//   with the stage record, and then through the result register.
//   One word is accepted every cycle unless the stall below holds it; the buffer
//   RAM has one write and one read port, and every command needs at most one of each.
// Stall:
//   The result register and the read stage hold while m_tready is low, and
//   s_tready drops only when both are full.
// Reset:
//   Buffer, temperature slots, positions, pending byte and header bytes return
//   to their initial values at once; per-entry valid bits make unwritten
//   buffer entries read as zero, so no clearing pass is needed.
`default_nettype none

module frame_capture_register_bridge #(
    parameter int FRAME_LEN = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // data_byte[7:0], addr_received[8],
                                        // adc_sample[20:9], zero[23:21]
    input  wire logic [2:0]  s_tuser,   // cmd[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // read_byte[7:0], dump_byte[15:8]
    output logic      [1:0]  m_tuser,   // status[0], dump_valid[1]
    input  wire logic        cfg_we,
    input  wire fcrb_pkg::reg_index_t cfg_index,
    input  wire logic [7:0]  cfg_wdata
);

    localparam int AW  = $clog2(FRAME_LEN);
    localparam int DPW = $clog2(FRAME_LEN + 1);
    localparam int RW  = (DPW > 8) ? DPW : 8;

    localparam logic [AW-1:0] SLOT_LO  = AW'(16);
    localparam logic [AW-1:0] SLOT_HI  = AW'(17);
    localparam logic [AW-1:0] POS_LAST = AW'(FRAME_LEN - 1);
    localparam logic [AW-1:0] POS_ONE  = AW'(1);
    localparam logic [DPW-1:0] DP_END  = DPW'(FRAME_LEN);
    localparam logic [RW-1:0]  RD_END  = RW'(FRAME_LEN);

    logic [7:0]           header_first_reg;
    logic [7:0]           header_second_reg;
    logic [AW-1:0]        write_pos_reg;
    logic [AW-1:0]        write_pos_next;
    logic [DPW-1:0]       dump_pos_reg;
    logic [DPW-1:0]       dump_pos_next;
    logic [FRAME_LEN-1:0] valid_reg;
    logic [FRAME_LEN-1:0] valid_next;
    logic [12:0]          temp_reg;
    logic [12:0]          temp_next;
    logic [12:0]          temp_calc;
    logic                 s1_valid_reg;
    fcrb_pkg::stage_t     s1_reg;
    fcrb_pkg::stage_t     s1_next;

    fcrb_pkg::cmd_t cmd;
    logic [7:0]     in_data;
    logic           in_addr_new;
    logic [11:0]    in_sample;
    logic           accept;
    logic           out_free;
    logic           ram_we;
    logic           ram_re;
    logic [7:0]     ram_q;
    logic [RW-1:0]  rd_wide;
    logic [AW-1:0]  rd_idx;
    logic           lookup_use_ram;
    logic [7:0]     lookup_val;

    assign cmd         = fcrb_pkg::cmd_t'(s_tuser);
    assign in_data     = s_tdata[7:0];
    assign in_addr_new = s_tdata[8];
    assign in_sample   = s_tdata[20:9];

    assign s_tready = !s1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    fcrb_temp u_temp (
        .sample (in_sample),
        .temp   (temp_calc)
    );

    // Read address: the received address for address events, the dump
    // position for dump-next, zero otherwise (including dump start)
    always_comb
    begin
        unique case (cmd)
            fcrb_pkg::CMD_ADDR:       rd_wide = RW'(in_data);
            fcrb_pkg::CMD_DUMP_NEXT:  rd_wide = RW'(dump_pos_reg);
            default:                  rd_wide = '0;
        endcase
        rd_idx = rd_wide[AW-1:0];
    end

    // Temperature slots, out-of-range addresses and never-written entries come
    // from flops, the rest from the RAM
    always_comb
    begin
        lookup_use_ram = 1'b0;
        lookup_val     = '0;
        if (rd_wide >= RD_END)
        begin
            lookup_val = '0;
        end
        else if (rd_idx == SLOT_LO)
        begin
            lookup_val = temp_reg[7:0];
        end
        else if (rd_idx == SLOT_HI)
        begin
            lookup_val = {3'b000, temp_reg[12:8]};
        end
        else if (valid_reg[rd_idx])
        begin
            lookup_use_ram = 1'b1;
        end
    end

    always_comb
    begin
        write_pos_next    = write_pos_reg;
        dump_pos_next     = dump_pos_reg;
        valid_next        = valid_reg;
        temp_next         = temp_reg;
        ram_we            = 1'b0;
        ram_re            = 1'b0;
        s1_next.kind      = fcrb_pkg::RES_NONE;
        s1_next.status    = 1'b0;
        s1_next.use_ram   = lookup_use_ram;
        s1_next.fixed_val = lookup_val;
        unique case (cmd)
            fcrb_pkg::CMD_STREAM:
            begin
                if (write_pos_reg == '0 && in_data != header_first_reg)
                begin
                    s1_next.status = 1'b1;
                end
                else if (write_pos_reg == POS_ONE && in_data != header_second_reg)
                begin
                    s1_next.status = 1'b1;
                    write_pos_next = '0;
                end
                else
                begin
                    if (write_pos_reg != SLOT_LO && write_pos_reg != SLOT_HI)
                    begin
                        ram_we                    = accept;
                        valid_next[write_pos_reg] = 1'b1;
                    end
                    write_pos_next = (write_pos_reg == POS_LAST) ? '0
                                                                 : write_pos_reg + 1'b1;
                end
            end
            fcrb_pkg::CMD_ADDR:
            begin
                ram_re       = accept && in_addr_new;
                s1_next.kind = in_addr_new ? fcrb_pkg::RES_READ_NEW
                                           : fcrb_pkg::RES_READ_OLD;
            end
            fcrb_pkg::CMD_TEMP:
            begin
                temp_next = temp_calc;
            end
            fcrb_pkg::CMD_DUMP_START:
            begin
                ram_re        = accept;
                s1_next.kind  = fcrb_pkg::RES_DUMP;
                dump_pos_next = DPW'(1);
            end
            fcrb_pkg::CMD_DUMP_NEXT:
            begin
                if (dump_pos_reg < DP_END)
                begin
                    ram_re        = accept;
                    s1_next.kind  = fcrb_pkg::RES_DUMP;
                    dump_pos_next = dump_pos_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg  <= 8'h50;
            header_second_reg <= 8'h54;
            write_pos_reg     <= '0;
            dump_pos_reg      <= '0;
            valid_reg         <= '0;
            temp_reg          <= '0;
            s1_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == fcrb_pkg::REG_HEADER_FIRST)
            begin
                header_first_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == fcrb_pkg::REG_HEADER_SECOND)
            begin
                header_second_reg <= cfg_wdata;
            end
            if (accept)
            begin
                write_pos_reg <= write_pos_next;
                dump_pos_reg  <= dump_pos_next;
                valid_reg     <= valid_next;
                temp_reg      <= temp_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

    fcrb_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_LEN)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (write_pos_reg),
        .wdata (in_data),
        .re    (ram_re),
        .raddr (rd_idx),
        .rdata (ram_q)
    );

    fcrb_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid_reg),
        .s1       (s1_reg),
        .ram_q    (ram_q),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

>>> tb/tb_frame_capture_register_bridge.sv
// Testbench for frame_capture_register_bridge: directed table, then random phases
// with header reprogramming, checked word by word against an in-bench predictor.
// Depends on fcrb_pkg and the frame_capture_register_bridge RTL.
module tb_frame_capture_register_bridge;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_LEN        = 32;
    localparam int SLOT_TEMP_LO     = 16;
    localparam int SLOT_TEMP_HI     = 17;
    localparam int unsigned TEMP_OFFSET_Q16 = 5386 * 65536;
    localparam int unsigned TEMP_SLOPE_Q16  = 196465;
    localparam logic [7:0] HDR_FIRST_RESET  = 8'h50;
    localparam logic [7:0] HDR_SECOND_RESET = 8'h54;
    localparam logic [2:0] CMD_RESERVED_LO  = 3'd5;
    localparam logic [2:0] CMD_RESERVED_HI  = 3'd7;
    localparam fcrb_pkg::reg_index_t REG_SPARE_A = 2'd2;
    localparam fcrb_pkg::reg_index_t REG_SPARE_B = 2'd3;
    localparam int PHASES           = 8;
    localparam int PHASE_WORDS      = 66;
    localparam int LONG_HOLD_CYCLES = 64;
    localparam int PROBE_ROWS       = 26;

    typedef struct packed {
        logic       status;
        logic [7:0] read_byte;
        logic       dump_valid;
        logic [7:0] dump_byte;
    } bridge_result_t;

    typedef struct packed {
        logic [2:0]     cmd;
        logic [7:0]     data;
        logic           addr_new;
        logic [11:0]    sample;
        logic [5:0]     repeats;
        logic           typed;
        bridge_result_t due;
    } probe_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // data_byte[7:0], addr_received[8], adc_sample[20:9], zero[23:21]
    logic [2:0]  s_tuser;    // cmd[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // read_byte[7:0], dump_byte[15:8]
    logic [1:0]  m_tuser;    // status[0], dump_valid[1]
    logic        cfg_we;
    fcrb_pkg::reg_index_t cfg_index;
    logic [7:0]  cfg_wdata;

    // Predictor state
    logic [7:0] hdr_first  = HDR_FIRST_RESET;
    logic [7:0] hdr_second = HDR_SECOND_RESET;
    logic [7:0] frame_mem [FRAME_LEN];
    logic [4:0] wr_pos     = '0;
    logic [7:0] pending_rd = '0;
    logic [5:0] dump_pos   = '0;

    bridge_result_t results_due [$];
    int words_sent      = 0;
    int results_checked = 0;
    int mismatch_count  = 0;
    int send_gap_max    = 11;
    int recv_stall_max  = 11;

    // Typed expectations hold for the reset headers and the zero-cleared buffer.
    probe_row_t probe_rows [PROBE_ROWS] = '{
        '{fcrb_pkg::CMD_ADDR,       8'h00, 1'b1, 12'h000, 6'd1, 1'b1, '{1'b0, 8'h00, 1'b0, 8'h00}},
        '{fcrb_pkg::CMD_ADDR,       8'hFF, 1'b1, 12'hFFF, 6'd1, 1'b1, '{1'b0, 8'h00, 1'b0, 8'h00}},
        '{fcrb_pkg::CMD_ADDR,       8'hAA, 1'b0, 12'h000, 6'd1, 1'b1, '{1'b0, 8'h00, 1'b0, 8'h00}},
        '{fcrb_pkg::CMD_DUMP_START, 8'hFF, 1'b1, 12'hFFF, 6'd1, 1'b1, '{1'b0, 8'h00, 1'b1, 8'h00}},
        '{fcrb_pkg::CMD_STREAM,     8'h00, 1'b0, 12'h000, 6'd1, 1'b1, '{1'b1, 8'h00, 1'b0, 8'h00}},
        '{fcrb_pkg::CMD_STREAM,     8'h50, 1'b1, 12'hFFF, 6'd1, 1'b1, '{1'b0, 8'h00, 1'b0, 8'h00}},
        '{fcrb_pkg::CMD_STREAM,     8'hFF, 1'b0, 12'h000, 6'd1, 1'b1, '{1'b1, 8'h00, 1'b0, 8'h00}},
        '{fcrb_pkg::CMD_STREAM,     8'h50, 1'b0, 12'h000, 6'd1, 1'b1, '{1'b0, 8'h00, 1'b0, 8'h00}},
        '{fcrb_pkg::CMD_STREAM,     8'h54, 1'b0, 12'h000, 6'd1, 1'b1, '{1'b0, 8'h00, 1'b0, 8'h00}},
        '{fcrb_pkg::CMD_STREAM,     8'hA5, 1'b1, 12'hA5A, 6'd30, 1'b0, '0},
        '{fcrb_pkg::CMD_STREAM,     8'h00, 1'b0, 12'h000, 6'd1, 1'b1, '{1'b1, 8'h00, 1'b0, 8'h00}},
        '{fcrb_pkg::CMD_TEMP,       8'hFF, 1'b1, 12'h000, 6'd1, 1'b1, '{1'b0, 8'h00, 1'b0, 8'h00}},
        '{fcrb_pkg::CMD_ADDR,       8'h10, 1'b1, 12'h000, 6'd1, 1'b1, '{1'b0, 8'h0A, 1'b0, 8'h00}},
        '{fcrb_pkg::CMD_ADDR,       8'h11, 1'b1, 12'h000, 6'd1, 1'b1, '{1'b0, 8'h15, 1'b0, 8'h00}},
        '{fcrb_pkg::CMD_ADDR,       8'h02, 1'b1, 12'h000, 6'd1, 1'b1, '{1'b0, 8'hA5, 1'b0, 8'h00}},
        '{fcrb_pkg::CMD_TEMP,       8'h00, 1'b0, 12'hFFF, 6'd1, 1'b1, '{1'b0, 8'h00, 1'b0, 8'h00}},
        '{fcrb_pkg::CMD_ADDR,       8'h11, 1'b1, 12'h000, 6'd1, 1'b1, '{1'b0, 8'h00, 1'b0, 8'h00}},
        '{fcrb_pkg::CMD_TEMP,       8'h00, 1'b0, 12'd1796, 6'd1, 1'b0, '0},
        '{fcrb_pkg::CMD_ADDR,       8'h10, 1'b1, 12'h000, 6'd1, 1'b0, '0},
        '{fcrb_pkg::CMD_ADDR,       8'h33, 1'b0, 12'h000, 6'd1, 1'b0, '0},
        '{fcrb_pkg::CMD_ADDR,       8'h1F, 1'b1, 12'h000, 6'd1, 1'b0, '0},
        '{fcrb_pkg::CMD_DUMP_START, 8'h00, 1'b0, 12'h000, 6'd1, 1'b0, '0},
        '{fcrb_pkg::CMD_DUMP_NEXT,  8'h00, 1'b0, 12'h000, 6'd31, 1'b0, '0},
        '{fcrb_pkg::CMD_DUMP_NEXT,  8'hFF, 1'b1, 12'hFFF, 6'd2, 1'b1, '{1'b0, 8'h00, 1'b0, 8'h00}},
        '{CMD_RESERVED_HI,          8'hFF, 1'b1, 12'hFFF, 6'd1, 1'b1, '{1'b0, 8'h00, 1'b0, 8'h00}},
        '{CMD_RESERVED_LO,          8'h00, 1'b0, 12'h000, 6'd1, 1'b1, '{1'b0, 8'h00, 1'b0, 8'h00}}
    };

    frame_capture_register_bridge #(.FRAME_LEN(FRAME_LEN)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #1_000_000;
        $display("FAIL frame_capture_register_bridge");
        $finish;
    end

    // Advance the predicted bridge state by one command and return its result word.
    function automatic bridge_result_t apply_command(input logic [2:0] cmd,
                                                     input logic [7:0] data,
                                                     input logic addr_new,
                                                     input logic [11:0] sample);
        bridge_result_t r;
        int unsigned    slope_term;
        logic [15:0]    temp;
        r = '0;
        case (cmd)
            fcrb_pkg::CMD_STREAM:
            begin
                if (wr_pos == 0 && data != hdr_first)
                begin
                    r.status = 1'b1;
                end
                else if (wr_pos == 1 && data != hdr_second)
                begin
                    r.status = 1'b1;
                    wr_pos = '0;
                end
                else
                begin
                    // temperature slots are stepped over, not written
                    if (wr_pos != SLOT_TEMP_LO && wr_pos != SLOT_TEMP_HI)
                        frame_mem[wr_pos] = data;
                    wr_pos = (wr_pos == FRAME_LEN - 1) ? '0 : wr_pos + 5'd1;
                end
            end
            fcrb_pkg::CMD_ADDR:
            begin
                if (addr_new)
                    pending_rd = (data < FRAME_LEN) ? frame_mem[data[4:0]] : 8'h00;
                r.read_byte = pending_rd;
            end
            fcrb_pkg::CMD_TEMP:
            begin
                slope_term = 32'(sample) * TEMP_SLOPE_Q16;
                temp = (slope_term >= TEMP_OFFSET_Q16) ? 16'd0
                                                       : 16'((TEMP_OFFSET_Q16 - slope_term) >> 16);
                frame_mem[SLOT_TEMP_LO] = temp[7:0];
                frame_mem[SLOT_TEMP_HI] = temp[15:8];
            end
            fcrb_pkg::CMD_DUMP_START:
            begin
                r.dump_valid = 1'b1;
                r.dump_byte  = frame_mem[0];
                dump_pos     = 6'd1;
            end
            fcrb_pkg::CMD_DUMP_NEXT:
            begin
                if (dump_pos < FRAME_LEN)
                begin
                    r.dump_valid = 1'b1;
                    r.dump_byte  = frame_mem[dump_pos[4:0]];
                    dump_pos     = dump_pos + 6'd1;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic send_word(input logic [2:0] cmd, input logic [7:0] data,
                             input logic addr_new, input logic [11:0] sample);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, sample, addr_new, data};
        do @(posedge clk); while (s_tready !== 1'b1);
        results_due.push_back(apply_command(cmd, data, addr_new, sample));
        words_sent++;
    endtask

    // Drop valid and hold until every outstanding result word is back.
    task automatic settle_outputs();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
    endtask

    task automatic load_headers(input logic [7:0] first, input logic [7:0] second);
        settle_outputs();
        repeat (2) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= fcrb_pkg::REG_HEADER_FIRST;
        cfg_wdata <= first;
        @(negedge clk);
        cfg_index <= fcrb_pkg::REG_HEADER_SECOND;
        cfg_wdata <= second;
        // spare indexes must be ignored
        @(negedge clk);
        cfg_index <= ($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B;
        cfg_wdata <= 8'($urandom_range(0, 255));
        @(negedge clk);
        cfg_we <= 1'b0;
        hdr_first  = first;
        hdr_second = second;
    endtask

    // Result side: random stall per word, a long hold-off at every 250th word from word 120, compare in order.
    initial
    begin
        bridge_result_t got;
        bridge_result_t due;
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (results_checked % 250 == 120)
                stall = LONG_HOLD_CYCLES;
            else
                stall = $urandom_range(0, recv_stall_max);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
            got.status     = m_tuser[0];
            got.dump_valid = m_tuser[1];
            got.read_byte  = m_tdata[7:0];
            got.dump_byte  = m_tdata[15:8];
            if (results_due.size() == 0)
            begin
                $error("result word with none expected: tdata %h tuser %h", m_tdata, m_tuser);
                mismatch_count++;
            end
            else
            begin
                due = results_due.pop_front();
                if (got.status !== due.status)
                begin
                    $error("status: expected %0d, got %0d", due.status, got.status);
                    mismatch_count++;
                end
                if (got.read_byte !== due.read_byte)
                begin
                    $error("read_byte: expected %h, got %h", due.read_byte, got.read_byte);
                    mismatch_count++;
                end
                if (got.dump_valid !== due.dump_valid)
                begin
                    $error("dump_valid: expected %0d, got %0d", due.dump_valid, got.dump_valid);
                    mismatch_count++;
                end
                if (got.dump_byte !== due.dump_byte)
                begin
                    $error("dump_byte: expected %h, got %h", due.dump_byte, got.dump_byte);
                    mismatch_count++;
                end
            end
            results_checked++;
            @(negedge clk);
        end
    end

    initial
    begin
        int phase;
        int phase_start;
        int pick;
        int n;
        logic [7:0] hdr_pick;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = fcrb_pkg::CMD_STREAM;
        cfg_we    = 1'b0;
        cfg_index = fcrb_pkg::REG_HEADER_FIRST;
        cfg_wdata = '0;
        foreach (frame_mem[i])
            frame_mem[i] = 8'h00;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (probe_rows[i])
        begin
            repeat (probe_rows[i].repeats)
            begin
                send_word(probe_rows[i].cmd, probe_rows[i].data,
                          probe_rows[i].addr_new, probe_rows[i].sample);
                if (probe_rows[i].typed)
                    results_due[results_due.size() - 1] = probe_rows[i].due;
            end
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            send_gap_max   = (phase % 3 == 1) ? 0 : 11;
            recv_stall_max = (phase % 4 == 1) ? 0 : 11;
            hdr_pick = 8'($urandom_range(0, 255));
            if (phase == 1)
                load_headers(8'h00, 8'hFF);
            else if (phase == 2)
                load_headers(8'hFF, 8'h00);
            else if (phase == 3)
                load_headers(hdr_pick, hdr_pick);
            else if (phase == PHASES - 1)
                load_headers(HDR_FIRST_RESET, HDR_SECOND_RESET);
            else if (phase != 0)
                load_headers(hdr_pick, 8'($urandom_range(0, 255)));

            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                begin
                    // well-formed frame, usually long enough to wrap
                    send_word(fcrb_pkg::CMD_STREAM, hdr_first, 1'($urandom_range(0, 1)),
                              12'($urandom_range(0, 4095)));
                    send_word(fcrb_pkg::CMD_STREAM, hdr_second, 1'($urandom_range(0, 1)),
                              12'($urandom_range(0, 4095)));
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : 30;
                    repeat (n)
                        send_word(fcrb_pkg::CMD_STREAM, 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)));
                end
                else if (pick < 50)
                begin
                    repeat ($urandom_range(1, 6))
                        send_word(fcrb_pkg::CMD_ADDR,
                                  ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                              : 8'($urandom_range(0, 31)),
                                  1'($urandom_range(0, 4) != 0), 12'($urandom_range(0, 4095)));
                end
                else if (pick < 60)
                begin
                    case ($urandom_range(0, 3))
                        0: n = $urandom_range(0, 4095);
                        1: n = $urandom_range(1790, 1800);
                        2: n = 0;
                        default: n = 4095;
                    endcase
                    send_word(fcrb_pkg::CMD_TEMP, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 12'(n));
                end
                else if (pick < 75)
                begin
                    if ($urandom_range(0, 4) != 0)
                        send_word(fcrb_pkg::CMD_DUMP_START, 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)));
                    n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 10)
                                                    : $urandom_range(31, 34);
                    repeat (n)
                        send_word(fcrb_pkg::CMD_DUMP_NEXT, 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)));
                end
                else if (pick < 82)
                begin
                    // broken header: wrong first byte, or good first and wrong second
                    if ($urandom_range(0, 1) == 0)
                    begin
                        send_word(fcrb_pkg::CMD_STREAM, hdr_first ^ 8'($urandom_range(1, 255)),
                                  1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)));
                    end
                    else
                    begin
                        send_word(fcrb_pkg::CMD_STREAM, hdr_first, 1'($urandom_range(0, 1)),
                                  12'($urandom_range(0, 4095)));
                        send_word(fcrb_pkg::CMD_STREAM, hdr_second ^ 8'($urandom_range(1, 255)),
                                  1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)));
                    end
                end
                else if (pick < 92)
                begin
                    send_word(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)));
                end
                else if (pick < 96)
                begin
                    send_word(3'($urandom_range(CMD_RESERVED_LO, CMD_RESERVED_HI)),
                              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              12'($urandom_range(0, 4095)));
                end
                else
                begin
                    settle_outputs();
                end
            end
        end

        settle_outputs();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS frame_capture_register_bridge");
        else
            $display("FAIL frame_capture_register_bridge");
        $finish;
    end

endmodule
